### design/hmq_pkg.sv
// Shared types and constants for the binary min-heap queue.
package hmq_pkg;

  // Operation codes
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2,
    OP_DELETE   = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_ROOT_RD,
    S_ROOT_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FINISH
  } state_e;

  localparam logic signed [31:0] KeyMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] KeyMin = 32'sh8000_0000;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] key_value;
    logic [5:0]         slot_index;
  } heap_in_t;

  typedef struct packed {
    logic signed [31:0] min_key;
    status_e            status;
    logic [6:0]         entry_count;
  } heap_out_t;

endpackage

### design/binary_min_heap_queue.sv
// Binary min-heap priority queue held in a single synchronous memory.
//
// Channels: an input transfer carries op, key_value and slot_index; each one
// yields exactly one output transfer with min_key, status and entry_count.
// One operation is in flight at a time; in_ready_o is high only while the
// sequencer is idle. Each heap level takes a read state that issues the
// memory read and a compare state that compares the registered read data
// and writes back. Insert and decrease climb toward the root; extract
// takes the root, moves the last entry there and walks it down; delete
// is a climb to the root followed by an extract. The moving key stays in
// a register while the hole walks the tree, so every level writes one
// entry and reads at most two. Out-of-range, empty and full cases skip
// the tree and go straight to the result.
// Reset empties the heap at once (count cleared); memory contents are not
// cleared and are never read before being written.
// A result waits in the output register while the receiver stalls; the
// block finishes its next item and holds it until that register frees.
module binary_min_heap_queue #(
  parameter int CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hmq_pkg::heap_in_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hmq_pkg::heap_out_t out_data_o
);
  import hmq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;

  // Heap storage
  logic signed [31:0] heap_mem [CAPACITY];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr_a, mem_raddr_b;
  logic signed [31:0] mem_wdata, rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= heap_mem[mem_raddr_a];
    rd_b_q <= heap_mem[mem_raddr_b];
  end

  // Control and working registers
  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic signed [31:0] key_q, key_d;
  op_e                op_q, op_d;
  logic signed [31:0] res_key_q, res_key_d;
  status_e            res_st_q, res_st_d;
  logic               out_valid_q, out_valid_d;
  heap_out_t          out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    key_q     <= key_d;
    op_q      <= op_d;
    res_key_q <= res_key_d;
    res_st_q  <= res_st_d;
    out_q     <= out_d;
  end

  // Tree arithmetic
  logic [AW-1:0]  parent;
  logic [LW-1:0]  lc, rc;
  logic [LW-1:0]  count_ext;
  logic [CW+5:0]  slot_ext, cnt_slot_ext;
  logic           rc_ok, take_l, take_r;

  assign parent       = (pos_q - AW'(1)) >> 1;
  assign lc           = {1'b0, pos_q, 1'b1};
  assign rc           = lc + LW'(1);
  assign count_ext    = LW'(count_q);
  assign slot_ext     = (CW + 6)'(in_data_i.slot_index);
  assign cnt_slot_ext = (CW + 6)'(count_q);
  assign rc_ok        = rc < count_ext;
  assign take_l       = rd_a_q < key_q;
  assign take_r       = rc_ok && (rd_b_q < (take_l ? rd_a_q : key_q));

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer: next state, memory access and result capture
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    key_d       = key_q;
    op_d        = op_q;
    res_key_d   = res_key_q;
    res_st_d    = res_st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = key_q;
    mem_raddr_a = parent;
    mem_raddr_b = parent;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_data_i.op;
          res_key_d = '0;
          res_st_d  = ST_OK;
          case (in_data_i.op)
            OP_INSERT: begin
              if (count_q >= CW'(CAPACITY)) begin
                res_st_d = ST_FULL;
                state_d  = S_FINISH;
              end else begin
                key_d   = in_data_i.key_value;
                pos_d   = AW'(count_q);
                count_d = count_q + CW'(1);
                state_d = S_UP_RD;
              end
            end
            OP_EXTRACT: begin
              if (count_q == '0) begin
                res_key_d = KeyMax;
                res_st_d  = ST_EMPTY;
                state_d   = S_FINISH;
              end else begin
                state_d = S_ROOT_RD;
              end
            end
            default: begin
              if (slot_ext >= cnt_slot_ext) begin
                res_st_d = ST_RANGE;
                state_d  = S_FINISH;
              end else begin
                key_d   = (in_data_i.op == OP_DELETE) ? KeyMin : in_data_i.key_value;
                pos_d   = AW'(in_data_i.slot_index);
                state_d = S_UP_RD;
              end
            end
          endcase
        end
      end

      // Climb: fetch the parent, or settle at the root
      S_UP_RD: begin
        if (pos_q == '0) begin
          mem_we  = 1'b1;
          state_d = (op_q == OP_DELETE) ? S_ROOT_RD : S_FINISH;
        end else begin
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_we = 1'b1;
        if (rd_a_q > key_q) begin
          mem_wdata = rd_a_q;
          pos_d     = parent;
          state_d   = S_UP_RD;
        end else begin
          state_d = (op_q == OP_DELETE) ? S_ROOT_RD : S_FINISH;
        end
      end

      // Take the root: read it and the last entry
      S_ROOT_RD: begin
        mem_raddr_a = '0;
        mem_raddr_b = AW'(count_q - CW'(1));
        count_d     = count_q - CW'(1);
        state_d     = S_ROOT_CMP;
      end

      S_ROOT_CMP: begin
        if (op_q == OP_EXTRACT) begin
          res_key_d = rd_a_q;
        end
        key_d   = rd_b_q;
        pos_d   = '0;
        state_d = (count_q == '0) ? S_FINISH : S_DN_RD;
      end

      // Descend: fetch both children, or settle at a leaf
      S_DN_RD: begin
        mem_raddr_a = AW'(lc);
        mem_raddr_b = AW'(rc);
        if (lc >= count_ext) begin
          mem_we  = 1'b1;
          state_d = S_FINISH;
        end else begin
          state_d = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        mem_we = 1'b1;
        if (take_r) begin
          mem_wdata = rd_b_q;
          pos_d     = AW'(rc);
          state_d   = S_DN_RD;
        end else if (take_l) begin
          mem_wdata = rd_a_q;
          pos_d     = AW'(lc);
          state_d   = S_DN_RD;
        end else begin
          state_d = S_FINISH;
        end
      end

      // Hand the result to the output register once it frees
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.min_key     = res_key_q;
          out_d.status      = res_st_q;
          out_d.entry_count = 7'(count_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

### design/hmq_checker.sv
// Port-level checker for the binary min-heap queue, with its bind.
module hmq_checker #(
  parameter int CAPACITY = 64
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input hmq_pkg::heap_in_t in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input hmq_pkg::heap_out_t out_data_o
);
  import hmq_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Stay busy right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready after transfer");

  // Report an empty extract with the top key and no entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |->
      out_data_o.min_key == KeyMax && out_data_o.entry_count == '0)
    else $error("bad empty result");

  // Drop an insert only at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |->
      out_data_o.entry_count == 7'(CAPACITY))
    else $error("full reported below capacity");

  // Return a zero key on range and full errors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_RANGE || out_data_o.status == ST_FULL) |->
      out_data_o.min_key == '0)
    else $error("nonzero key on error");

endmodule

bind binary_min_heap_queue hmq_checker #(.CAPACITY(CAPACITY)) u_hmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### test/tb_binary_min_heap_queue.sv
// Testbench for the binary min-heap queue: random and directed operations checked against a heap model.
module tb_binary_min_heap_queue;
  import hmq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 64;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  heap_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  heap_out_t out_data_o;

  binary_min_heap_queue #(.CAPACITY(Depth)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #2 clk_i = ~clk_i;

  // Predictor state
  logic signed [31:0] heap_keys[Depth];
  int unsigned        heap_size = 0;

  heap_in_t  pending_ops[$];
  heap_out_t expected_results[$];
  int        fail_count = 0;
  int        checked = 0;
  int        cycle_count = 0;
  bit        stim_done = 0;
  bit        long_stall_req = 0;
  int        op_seen[4] = '{0, 0, 0, 0};
  int        status_seen[4] = '{0, 0, 0, 0};

  function automatic void swap_keys(int unsigned a, int unsigned b);
    logic signed [31:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void climb(int unsigned pos);
    int unsigned up;
    while (pos != 0) begin
      up = (pos - 1) / 2;
      if (heap_keys[up] <= heap_keys[pos]) break;
      swap_keys(up, pos);
      pos = up;
    end
  endfunction

  function automatic void descend(int unsigned pos);
    int unsigned lc, rc, best;
    forever begin
      lc = 2 * pos + 1;
      rc = lc + 1;
      best = pos;
      if (lc < heap_size && heap_keys[lc] < heap_keys[best]) best = lc;
      if (rc < heap_size && heap_keys[rc] < heap_keys[best]) best = rc;
      if (best == pos) break;
      swap_keys(pos, best);
      pos = best;
    end
  endfunction

  function automatic logic signed [31:0] pop_root();
    logic signed [31:0] top;
    top = heap_keys[0];
    heap_size--;
    if (heap_size > 0) begin
      heap_keys[0] = heap_keys[heap_size];
      descend(0);
    end
    return top;
  endfunction

  // Compute the result of one accepted operation and update the model heap
  function automatic heap_out_t predict_heap_op(heap_in_t item);
    heap_out_t r;
    logic signed [31:0] unused_key;
    r = '0;
    r.status = ST_OK;
    case (item.op)
      OP_INSERT: begin
        if (heap_size >= Depth) begin
          r.status = ST_FULL;
        end else begin
          heap_keys[heap_size] = item.key_value;
          heap_size++;
          climb(heap_size - 1);
        end
      end
      OP_EXTRACT: begin
        if (heap_size == 0) begin
          r.min_key = KeyMax;
          r.status = ST_EMPTY;
        end else begin
          r.min_key = pop_root();
        end
      end
      default: begin
        if (item.slot_index >= heap_size) begin
          r.status = ST_RANGE;
        end else if (item.op == OP_DECREASE) begin
          heap_keys[item.slot_index] = item.key_value;
          climb(item.slot_index);
        end else begin
          heap_keys[item.slot_index] = KeyMin;
          climb(item.slot_index);
          unused_key = pop_root();
        end
      end
    endcase
    r.entry_count = 7'(heap_size);
    return r;
  endfunction

  function automatic heap_in_t make_op(op_e op, logic signed [31:0] key, logic [5:0] slot);
    heap_in_t it;
    it.op = op;
    it.key_value = key;
    it.slot_index = slot;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return KeyMax;
      1: return KeyMin;
      2: return 32'(int'($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  // Drive the input channel from the pending queue with random gaps
  int gap_left = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(predict_heap_op(in_data_i));
        op_seen[in_data_i.op]++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_data_i <= pending_ops.pop_front();
          in_valid_i <= 1'b1;
          gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                    : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Sample results, compare them and apply random backpressure
  int stall_left = 0;
  always @(posedge clk_i) begin
    heap_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        checked++;
        if (expected_results.size() == 0) begin
          $error("result with no operation pending: %p", out_data_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          status_seen[out_data_o.status]++;
          if (out_data_o.min_key !== want.min_key) begin
            $error("min_key: expected %0d, got %0d", want.min_key, out_data_o.min_key);
            fail_count++;
          end
          if (out_data_o.status !== want.status) begin
            $error("status: expected %s, got %s", want.status.name(),
                   out_data_o.status.name());
            fail_count++;
          end
          if (out_data_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_data_o.entry_count);
            fail_count++;
          end
        end
      end
      if (long_stall_req) begin
        long_stall_req <= 1'b0;
        stall_left <= 300;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left <= ($urandom_range(0, 12) == 0) ? $urandom_range(10, 60)
                    : $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Give up once the cycle limit is reached
  always @(posedge clk_i) begin
    if (cycle_count >= CycleLimit) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int n, burst;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty heap cases, extremes, every operation
    pending_ops.push_back(make_op(OP_EXTRACT, 32'sd0, 6'd0));
    pending_ops.push_back(make_op(OP_DECREASE, 32'sd5, 6'd0));
    pending_ops.push_back(make_op(OP_DELETE, 32'sd0, 6'd63));
    pending_ops.push_back(make_op(OP_INSERT, KeyMax, 6'd0));
    pending_ops.push_back(make_op(OP_INSERT, KeyMin, 6'd63));
    pending_ops.push_back(make_op(OP_INSERT, 32'sd7, 6'd0));
    pending_ops.push_back(make_op(OP_INSERT, -32'sd3, 6'd0));
    pending_ops.push_back(make_op(OP_INSERT, 32'sd7, 6'd0));
    pending_ops.push_back(make_op(OP_DECREASE, 32'sd100, 6'd1));
    pending_ops.push_back(make_op(OP_DECREASE, KeyMin, 6'd4));
    pending_ops.push_back(make_op(OP_DECREASE, 32'sd0, 6'd5));
    pending_ops.push_back(make_op(OP_DELETE, 32'sd0, 6'd2));
    pending_ops.push_back(make_op(OP_DELETE, 32'sd0, 6'd0));
    pending_ops.push_back(make_op(OP_DELETE, 32'sd0, 6'd3));
    repeat (4) pending_ops.push_back(make_op(OP_EXTRACT, 32'sd0, 6'd0));
    wait_drained();

    // Fill to capacity with the receiver held off, then overflow
    long_stall_req = 1'b1;
    for (int i = 0; i < Depth + 3; i++)
      pending_ops.push_back(make_op(OP_INSERT, rand_key(), 6'($urandom)));
    pending_ops.push_back(make_op(OP_DECREASE, rand_key(), 6'd63));
    pending_ops.push_back(make_op(OP_DELETE, 32'sd0, 6'd63));
    for (int i = 0; i < Depth + 2; i++)
      pending_ops.push_back(make_op(OP_EXTRACT, $urandom, 6'($urandom)));
    wait_drained();

    // Random phases: bursts that grow, churn, then drain the heap
    n = 0;
    while (n < 330) begin
      burst = $urandom_range(20, 70);
      for (int i = 0; i < burst; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: pending_ops.push_back(make_op(OP_INSERT, rand_key(), 6'($urandom)));
          5, 6: pending_ops.push_back(make_op(OP_EXTRACT, rand_key(), 6'($urandom)));
          7: pending_ops.push_back(make_op(OP_DECREASE, rand_key(),
                                           6'($urandom_range(0, heap_size + 4))));
          default: pending_ops.push_back(make_op(OP_DELETE, rand_key(),
                                                 6'($urandom_range(0, heap_size + 4))));
        endcase
      end
      n += burst;
      if ($urandom_range(0, 2) == 0) wait_drained();
      else while (pending_ops.size() > 0) @(posedge clk_i);
    end
    wait_drained();
    for (int i = 0; i < Depth + 1; i++)
      pending_ops.push_back(make_op(OP_EXTRACT, rand_key(), 6'($urandom)));
    wait_drained();
    repeat (60) @(posedge clk_i);

    $display("checked %0d results: ops ins/ext/dec/del %0d/%0d/%0d/%0d", checked,
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("statuses ok/empty/full/range %0d/%0d/%0d/%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### files.f
design/hmq_pkg.sv
design/binary_min_heap_queue.sv
design/hmq_checker.sv
test/tb_binary_min_heap_queue.sv
